/* design/hsl2rgb_pkg.sv */
// Package: fixed-point constants, reciprocal multipliers and types for the HSL to RGB converter.
`default_nettype none
package hsl2rgb_pkg;

    localparam int FRAC_BITS = 24;
    localparam int FW = FRAC_BITS + 1;
    localparam int RECIP_EXTRA = 18;
    localparam int RECIP_SHIFT = FRAC_BITS + RECIP_EXTRA;

    typedef logic [FW-1:0] fx_t;
    typedef logic [FW:0] fx1_t;
    typedef logic [2*FW-1:0] fxw_t;

    localparam logic [63:0] ONE64 = 64'd1 << FRAC_BITS;
    localparam fx_t ONE = FW'(ONE64);
    localparam fx_t HALF = FW'(ONE64 >> 1);
    localparam fx_t THIRD = FW'(ONE64 / 3);
    localparam fx_t SIXTH = FW'(ONE64 / 6);
    localparam fx_t TWO_THIRDS = FW'((2 * ONE64) / 3);

    localparam logic [8:0] HUE_MAX = 9'd360;
    localparam logic [6:0] PCT_MAX = 7'd100;

    localparam logic [63:0] HUE_RECIP = ((64'd1 << RECIP_SHIFT) + 64'd359) / 64'd360;
    localparam logic [63:0] PCT_RECIP = ((64'd1 << RECIP_SHIFT) + 64'd99) / 64'd100;

    typedef enum logic [1:0] {
        RG_RISE,
        RG_HIGH,
        RG_FALL,
        RG_LOW
    } region_t;

endpackage
`default_nettype wire

/* design/hsl_to_rgb_converter.sv */
// Top level: five-stage pipelined HSL to RGB converter with RGB pass-through mode.
//
//   channel   signals                                    direction
//   config    cfg_wen, cfg_wdata                         in
//   input     in_valid, in_stall, hue .. in_blue         in (in_stall out)
//   output    out_valid, out_stall, red .. packed_color  out (out_stall in)
//
// One item per cycle unless a stalled output has backed up the pipeline; each item passes every stage in turn.
// Stages: scale, l*s and hue offsets, p/q and segment, slope product, level and byte.
// Reset clears all stage valid bits and selects RGB pass-through.
// A stalled output holds its stage; earlier stages keep filling empty slots.
`default_nettype none
module hsl_to_rgb_converter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic        cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [8:0]  hue,
    input  logic [6:0]  saturation,
    input  logic [6:0]  lightness,
    input  logic [7:0]  in_red,
    input  logic [7:0]  in_green,
    input  logic [7:0]  in_blue,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic [31:0] packed_color
);

    logic mode_reg;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    // stage 1
    logic [8:0]        hue_c;
    logic [6:0]        sat_c;
    logic [6:0]        lig_c;
    logic [63:0]       h_prod;
    logic [63:0]       s_prod;
    logic [63:0]       l_prod;
    hsl2rgb_pkg::fx_t  h1_next, s1_next, l1_next;
    hsl2rgb_pkg::fx_t  h1_reg, s1_reg, l1_reg;
    logic              mode1_reg;
    logic [7:0]        r1_reg, g1_reg, b1_reg;

    // stage 2
    hsl2rgb_pkg::fxw_t ls_full;
    hsl2rgb_pkg::fx1_t tr_sum;
    hsl2rgb_pkg::fx_t  ls2_next;
    hsl2rgb_pkg::fx_t  t2_next [3];
    hsl2rgb_pkg::fx_t  l2_reg, s2_reg, ls2_reg;
    hsl2rgb_pkg::fx_t  t2_reg [3];
    logic              mode2_reg;
    logic [7:0]        r2_reg, g2_reg, b2_reg;

    // stage 3
    hsl2rgb_pkg::fx1_t sum_ls, sum_ms, q_raw, two_l, p_raw, q_fix;
    hsl2rgb_pkg::fx_t  p3_next, q3_next, d3_next;
    hsl2rgb_pkg::fx_t  x3_next [3];
    hsl2rgb_pkg::region_t rg3_next [3];
    logic [hsl2rgb_pkg::FW+2:0] six_t [3];
    logic [hsl2rgb_pkg::FW+2:0] six_f [3];
    hsl2rgb_pkg::fx_t  fall_t [3];
    hsl2rgb_pkg::fx_t  p3_reg, q3_reg, d3_reg;
    hsl2rgb_pkg::fx_t  x3_reg [3];
    hsl2rgb_pkg::region_t rg3_reg [3];
    logic              mode3_reg;
    logic [7:0]        r3_reg, g3_reg, b3_reg;

    // stage 4
    hsl2rgb_pkg::fxw_t prod4 [3];
    hsl2rgb_pkg::fx_t  m4_next [3];
    hsl2rgb_pkg::fx_t  m4_reg [3];
    hsl2rgb_pkg::region_t rg4_reg [3];
    hsl2rgb_pkg::fx_t  p4_reg, q4_reg;
    logic              mode4_reg;
    logic [7:0]        r4_reg, g4_reg, b4_reg;

    // stage 5
    hsl2rgb_pkg::fx1_t c5 [3];
    logic [hsl2rgb_pkg::FW+8:0] scaled5 [3];
    logic [hsl2rgb_pkg::FW+8-hsl2rgb_pkg::FRAC_BITS:0] byte_hi [3];
    logic [7:0]        byte5 [3];
    logic [7:0]        red_next, green_next, blue_next;
    logic [7:0]        red_reg, green_reg, blue_reg;

    assign rdy5 = !v5_reg || !out_stall;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign in_stall = !rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                mode_reg <= cfg_wdata;
            end
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
            if (rdy5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    // stage 1: clamp, scale to fraction by exact reciprocal multiply
    always_comb
    begin
        hue_c = (hue > hsl2rgb_pkg::HUE_MAX) ? hsl2rgb_pkg::HUE_MAX : hue;
        sat_c = (saturation > hsl2rgb_pkg::PCT_MAX) ? hsl2rgb_pkg::PCT_MAX : saturation;
        lig_c = (lightness > hsl2rgb_pkg::PCT_MAX) ? hsl2rgb_pkg::PCT_MAX : lightness;
        h_prod = 64'(hue_c) * hsl2rgb_pkg::HUE_RECIP;
        s_prod = 64'(sat_c) * hsl2rgb_pkg::PCT_RECIP;
        l_prod = 64'(lig_c) * hsl2rgb_pkg::PCT_RECIP;
        h1_next = hsl2rgb_pkg::FW'(h_prod >> hsl2rgb_pkg::RECIP_EXTRA);
        s1_next = hsl2rgb_pkg::FW'(s_prod >> hsl2rgb_pkg::RECIP_EXTRA);
        l1_next = hsl2rgb_pkg::FW'(l_prod >> hsl2rgb_pkg::RECIP_EXTRA);
    end

    // stage 2: l*s and channel hue offsets
    always_comb
    begin
        ls_full = hsl2rgb_pkg::fxw_t'(l1_reg) * hsl2rgb_pkg::fxw_t'(s1_reg);
        ls2_next = hsl2rgb_pkg::FW'(ls_full >> hsl2rgb_pkg::FRAC_BITS);
        tr_sum = hsl2rgb_pkg::fx1_t'(h1_reg) + hsl2rgb_pkg::fx1_t'(hsl2rgb_pkg::THIRD);
        if (tr_sum > hsl2rgb_pkg::fx1_t'(hsl2rgb_pkg::ONE))
        begin
            t2_next[0] = hsl2rgb_pkg::FW'(tr_sum - hsl2rgb_pkg::fx1_t'(hsl2rgb_pkg::ONE));
        end
        else
        begin
            t2_next[0] = hsl2rgb_pkg::FW'(tr_sum);
        end
        t2_next[1] = h1_reg;
        if (h1_reg < hsl2rgb_pkg::THIRD)
        begin
            t2_next[2] = h1_reg + hsl2rgb_pkg::ONE - hsl2rgb_pkg::THIRD;
        end
        else
        begin
            t2_next[2] = h1_reg - hsl2rgb_pkg::THIRD;
        end
    end

    // stage 3: p, q and per-channel segment and slope operand
    always_comb
    begin
        sum_ls = hsl2rgb_pkg::fx1_t'(l2_reg) + hsl2rgb_pkg::fx1_t'(ls2_reg);
        sum_ms = hsl2rgb_pkg::fx1_t'(l2_reg) + hsl2rgb_pkg::fx1_t'(s2_reg)
                 - hsl2rgb_pkg::fx1_t'(ls2_reg);
        q_raw = (l2_reg < hsl2rgb_pkg::HALF) ? sum_ls : sum_ms;
        two_l = {l2_reg, 1'b0};
        p_raw = (q_raw > two_l) ? '0 : two_l - q_raw;
        q_fix = (q_raw < p_raw) ? p_raw : q_raw;
        p3_next = hsl2rgb_pkg::FW'(p_raw);
        q3_next = hsl2rgb_pkg::FW'(q_fix);
        d3_next = q3_next - p3_next;
        for (int i = 0; i < 3; i++)
        begin
            fall_t[i] = hsl2rgb_pkg::TWO_THIRDS - t2_reg[i];
            six_t[i] = ({3'b000, t2_reg[i]} << 2) + ({3'b000, t2_reg[i]} << 1);
            six_f[i] = ({3'b000, fall_t[i]} << 2) + ({3'b000, fall_t[i]} << 1);
            if (t2_reg[i] < hsl2rgb_pkg::SIXTH)
            begin
                rg3_next[i] = hsl2rgb_pkg::RG_RISE;
                x3_next[i] = hsl2rgb_pkg::FW'(six_t[i]);
            end
            else if (t2_reg[i] < hsl2rgb_pkg::HALF)
            begin
                rg3_next[i] = hsl2rgb_pkg::RG_HIGH;
                x3_next[i] = '0;
            end
            else if (t2_reg[i] < hsl2rgb_pkg::TWO_THIRDS)
            begin
                rg3_next[i] = hsl2rgb_pkg::RG_FALL;
                x3_next[i] = hsl2rgb_pkg::FW'(six_f[i]);
            end
            else
            begin
                rg3_next[i] = hsl2rgb_pkg::RG_LOW;
                x3_next[i] = '0;
            end
        end
    end

    // stage 4: slope products
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod4[i] = hsl2rgb_pkg::fxw_t'(d3_reg) * hsl2rgb_pkg::fxw_t'(x3_reg[i]);
            m4_next[i] = hsl2rgb_pkg::FW'(prod4[i] >> hsl2rgb_pkg::FRAC_BITS);
        end
    end

    // stage 5: pick level, scale by 255, select mode
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            case (rg4_reg[i])
                hsl2rgb_pkg::RG_RISE, hsl2rgb_pkg::RG_FALL:
                    c5[i] = hsl2rgb_pkg::fx1_t'(p4_reg) + hsl2rgb_pkg::fx1_t'(m4_reg[i]);
                hsl2rgb_pkg::RG_HIGH:
                    c5[i] = hsl2rgb_pkg::fx1_t'(q4_reg);
                default:
                    c5[i] = hsl2rgb_pkg::fx1_t'(p4_reg);
            endcase
            scaled5[i] = ({8'h00, c5[i]} << 8) - {8'h00, c5[i]};
            byte_hi[i] = scaled5[i][hsl2rgb_pkg::FW+8:hsl2rgb_pkg::FRAC_BITS];
            byte5[i] = (byte_hi[i] > 255) ? 8'hFF : byte_hi[i][7:0];
        end
        red_next   = mode4_reg ? byte5[0] : r4_reg;
        green_next = mode4_reg ? byte5[1] : g4_reg;
        blue_next  = mode4_reg ? byte5[2] : b4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            h1_reg    <= h1_next;
            s1_reg    <= s1_next;
            l1_reg    <= l1_next;
            mode1_reg <= mode_reg;
            r1_reg    <= in_red;
            g1_reg    <= in_green;
            b1_reg    <= in_blue;
        end
        if (rdy2)
        begin
            l2_reg    <= l1_reg;
            s2_reg    <= s1_reg;
            ls2_reg   <= ls2_next;
            t2_reg    <= t2_next;
            mode2_reg <= mode1_reg;
            r2_reg    <= r1_reg;
            g2_reg    <= g1_reg;
            b2_reg    <= b1_reg;
        end
        if (rdy3)
        begin
            p3_reg    <= p3_next;
            q3_reg    <= q3_next;
            d3_reg    <= d3_next;
            x3_reg    <= x3_next;
            rg3_reg   <= rg3_next;
            mode3_reg <= mode2_reg;
            r3_reg    <= r2_reg;
            g3_reg    <= g2_reg;
            b3_reg    <= b2_reg;
        end
        if (rdy4)
        begin
            m4_reg    <= m4_next;
            rg4_reg   <= rg3_reg;
            p4_reg    <= p3_reg;
            q4_reg    <= q3_reg;
            mode4_reg <= mode3_reg;
            r4_reg    <= r3_reg;
            g4_reg    <= g3_reg;
            b4_reg    <= b3_reg;
        end
        if (rdy5)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign out_valid    = v5_reg;
    assign red          = red_reg;
    assign green        = green_reg;
    assign blue         = blue_reg;
    assign packed_color = {8'hFF, blue_reg, green_reg, red_reg};

`ifndef SYNTH
    a_transfer_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> v1_reg)
        else $error("accepted transfer did not reach stage 1");

    a_p_below_q: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |-> p3_reg <= q3_reg)
        else $error("p exceeds q");

    a_slope_operand_range: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |-> (x3_reg[0] <= hsl2rgb_pkg::ONE) && (x3_reg[1] <= hsl2rgb_pkg::ONE)
                   && (x3_reg[2] <= hsl2rgb_pkg::ONE))
        else $error("slope operand out of range");

    a_s4_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg && !rdy5 |=> v4_reg && $stable(m4_reg[0]) && $stable(m4_reg[1])
                            && $stable(m4_reg[2]) && $stable(p4_reg))
        else $error("stage 4 changed while held");
`endif

endmodule
`default_nettype wire
